// File: hw/rtl/pls_pkg.sv
package pls_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int PIX_W         = 8;
    localparam int LIGHT_W       = 7;
    localparam int SAT_W         = 7;
    localparam int HUE_W         = 9;

    localparam logic [LIGHT_W-1:0] LIGHT_RESET = 7'd50;
    localparam logic [LIGHT_W-1:0] LIGHT_MAX   = 7'd100;
    localparam logic [LIGHT_W-1:0] LIGHT_HALF  = 7'd50;

    // saturation and hue handed from front to back
    typedef struct packed {
        logic [SAT_W-1:0] sat;
        logic [HUE_W-1:0] hue;
    } hs_t;

    // piece of the hue-to-channel curve
    typedef enum logic [1:0] {
        SEG_RISE,
        SEG_TOP,
        SEG_FALL,
        SEG_BOT
    } seg_t;

endpackage

// File: hw/rtl/pls_if.sv
interface pls_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

interface pls_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    output ready);
endinterface

// File: hw/rtl/pls_div.sv
// Pipelined restoring divider, one quotient bit per stage: q = a * 2^(QBITS-1) / b, a <= b.
module pls_div #(
    parameter int QBITS = 17,
    parameter int DW    = 9,
    parameter int PW    = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_vld,
    input  logic [DW-1:0]    a,
    input  logic [DW-1:0]    b,
    input  logic [PW-1:0]    pay_in,
    output logic             out_vld,
    output logic [QBITS-1:0] q,
    output logic [PW-1:0]    pay_out
);

    localparam int RW = DW + 1;

    logic             vld_reg [QBITS];
    logic [RW-1:0]    rem_reg [QBITS];
    logic [DW-1:0]    den_reg [QBITS];
    logic [QBITS-1:0] quo_reg [QBITS];
    logic [PW-1:0]    pay_reg [QBITS];

    for (genvar k = 0; k < QBITS; k++) begin : g_stage
        logic             vld_prev;
        logic [RW-1:0]    rem_prev;
        logic [DW-1:0]    den_prev;
        logic [QBITS-1:0] quo_prev;
        logic [PW-1:0]    pay_prev;
        logic [RW-1:0]    trial;
        logic             qbit;
        logic [RW-1:0]    rem_next;

        if (k == 0) begin : g_first
            assign vld_prev = in_vld;
            assign rem_prev = RW'(a);
            assign den_prev = b;
            assign quo_prev = '0;
            assign pay_prev = pay_in;
            assign trial    = rem_prev;
        end
        else begin : g_next
            assign vld_prev = vld_reg[k-1];
            assign rem_prev = rem_reg[k-1];
            assign den_prev = den_reg[k-1];
            assign quo_prev = quo_reg[k-1];
            assign pay_prev = pay_reg[k-1];
            assign trial    = rem_prev << 1;
        end

        assign qbit     = (trial >= RW'(den_prev));
        assign rem_next = qbit ? (trial - RW'(den_prev)) : trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_prev;
                quo_reg[k] <= {quo_prev[QBITS-2:0], qbit};
                pay_reg[k] <= pay_prev;
            end
        end
    end

    assign out_vld = vld_reg[QBITS-1];
    assign q       = quo_reg[QBITS-1];
    assign pay_out = pay_reg[QBITS-1];

endmodule

// File: hw/rtl/pls_front.sv
// RGB to whole-degree hue and whole-percent saturation.
module pls_front #(
    parameter int FRAC_BITS = pls_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    pls_in_if.sink       pix,
    input  logic         full,
    output logic         push,
    output pls_pkg::hs_t push_data
);

    localparam int QW = FRAC_BITS + 1;
    localparam int XW = FRAC_BITS + 4;
    localparam int HW = XW + 6;
    localparam int SW = QW + 7;
    localparam logic signed [HW-1:0] FULL_TURN = HW'(longint'(360) <<< FRAC_BITS);

    logic [7:0]        r, g, b, mx, mn, d, num_abs;
    logic [8:0]        sum, den;
    logic signed [8:0] num;
    logic              num_neg, grey, en;
    logic [2:0]        base;

    logic              sat_vld, hue_vld, sat_grey;
    logic [QW-1:0]     sat_q, hue_q;
    logic [3:0]        hue_pay;

    logic [SW-1:0]        s_full;
    logic signed [XW-1:0] hq, x;
    logic signed [HW-1:0] hh, hh_pos;

    always_comb
    begin
        r = pix.red_in;
        g = pix.green_in;
        b = pix.blue_in;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d    = mx - mn;
        sum  = {1'b0, mx} + {1'b0, mn};
        den  = (sum < 9'd255) ? sum : (9'd510 - sum);
        grey = (mx == mn);
        if (mx == b)
        begin
            base = 3'd4;
            num  = $signed({1'b0, r}) - $signed({1'b0, g});
        end
        else if (mx == g)
        begin
            base = 3'd2;
            num  = $signed({1'b0, b}) - $signed({1'b0, r});
        end
        else
        begin
            base = 3'd0;
            num  = $signed({1'b0, g}) - $signed({1'b0, b});
        end
        num_neg = num[8];
        num_abs = num_neg ? 8'(-num) : num[7:0];
    end

    assign en        = !sat_vld || !full;
    assign pix.ready = en;

    pls_div #(.QBITS(QW), .DW(9), .PW(1)) u_sat_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (pix.valid),
        .a       ({1'b0, d}),
        .b       (den),
        .pay_in  (grey),
        .out_vld (sat_vld),
        .q       (sat_q),
        .pay_out (sat_grey)
    );

    pls_div #(.QBITS(QW), .DW(9), .PW(4)) u_hue_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (pix.valid),
        .a       ({1'b0, num_abs}),
        .b       ({1'b0, d}),
        .pay_in  ({base, num_neg}),
        .out_vld (hue_vld),
        .q       (hue_q),
        .pay_out (hue_pay)
    );

    always_comb
    begin
        s_full = SW'(sat_q) * SW'(100);
        hq     = $signed(XW'(hue_q));
        if (hue_pay[0]) hq = -hq;
        x      = $signed(XW'({hue_pay[3:1], {FRAC_BITS{1'b0}}})) + hq;
        hh     = HW'(x) * HW'(60);
        hh_pos = (hh < 0) ? (hh + FULL_TURN) : hh;
        push_data.sat = sat_grey ? '0 : s_full[FRAC_BITS+6:FRAC_BITS];
        push_data.hue = sat_grey ? '0 : hh_pos[FRAC_BITS+8:FRAC_BITS];
    end

    assign push = sat_vld && hue_vld && !full;

endmodule

// File: hw/rtl/pls_fifo.sv
// Two-entry queue between front and back.
module pls_fifo (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  pls_pkg::hs_t push_data,
    input  logic         pop,
    output logic         full,
    output logic         vld,
    output pls_pkg::hs_t pop_data
);

    localparam int DEPTH = 2;
    localparam int AW    = $clog2(DEPTH);

    pls_pkg::hs_t   mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]    cnt_reg, cnt_next;
    logic           do_push, do_pop;

    assign full     = (cnt_reg == (AW+1)'(DEPTH));
    assign vld      = (cnt_reg != '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && vld;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop) cnt_next = cnt_reg + 1'b1;
        if (do_pop && !do_push) cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: hw/rtl/pls_back.sv
// HSL to RGB at the programmed lightness.
module pls_back #(
    parameter int FRAC_BITS = pls_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [pls_pkg::LIGHT_W-1:0] lightness,
    input  logic                        fifo_vld,
    input  pls_pkg::hs_t                fifo_data,
    output logic                        pop,
    pls_out_if.source                   pix
);

    localparam int QW  = FRAC_BITS + 1;
    localparam int PW  = FRAC_BITS + 4;
    localparam int MW  = 2 * FRAC_BITS + 3;
    localparam int CW  = PW + 7;
    localparam int HS  = 17;
    localparam int HPW = QW + HS;
    localparam logic [QW-1:0] ONE = QW'(longint'(1) <<< FRAC_BITS);
    localparam logic [QW-1:0] K3  = QW'((longint'(33333) <<< FRAC_BITS) / 100000);
    localparam logic [QW-1:0] K6  = QW'((longint'(66666) <<< FRAC_BITS) / 100000);
    // hue * 2^FRAC_BITS / 360 as a multiply by a rounded-up reciprocal, exact for hue < 360
    localparam logic [QW+7:0] HUE_RECIP =
        (QW+8)'(((longint'(1) <<< (FRAC_BITS + HS)) + 359) / 360);

    typedef logic [127:0][QW-1:0] pct_tab_t;
    typedef logic [127:0][7:0]    byte_tab_t;

    function automatic pct_tab_t build_pct();
        pct_tab_t tab;
        for (int i = 0; i < 128; i++) tab[i] = QW'((longint'(i) <<< FRAC_BITS) / 100);
        return tab;
    endfunction

    function automatic byte_tab_t build_byte();
        byte_tab_t tab;
        longint    f;
        for (int i = 0; i < 128; i++)
        begin
            f      = (longint'(i) <<< FRAC_BITS) / 100;
            tab[i] = 8'((f * 255) >>> FRAC_BITS);
        end
        return tab;
    endfunction

    localparam pct_tab_t  PCT_TAB  = build_pct();
    localparam byte_tab_t BYTE_TAB = build_byte();

    logic en;

    // hue fraction
    logic                        a_grey, a_vld_reg, ga_reg;
    logic [QW-1:0]               a_lf, a_sf, hf_reg, lfa_reg, sfa_reg;
    logic [pls_pkg::LIGHT_W-1:0] la_reg;
    logic [HPW-1:0]              hprod;

    // t1/t2 and phases
    logic                        b_vld_reg;
    logic signed [PW-1:0]        t1_reg, t2_reg;
    logic [QW-1:0]               ph_reg [3];
    logic [pls_pkg::LIGHT_W-1:0] lb_reg;
    logic                        gb_reg;
    logic [QW:0]                 mb;
    logic [MW-1:0]               mprod;
    logic [QW+1:0]               t1_u;
    logic [QW:0]                 trs;
    logic [QW-1:0]               tr, tb;

    // products
    logic                        c_vld_reg;
    logic signed [2*PW-1:0]      prod_reg [3];
    pls_pkg::seg_t               seg_reg [3];
    logic signed [PW-1:0]        t1c_reg, t2c_reg;
    logic [pls_pkg::LIGHT_W-1:0] lc_reg;
    logic                        gc_reg;
    logic signed [PW-1:0]        d12;

    // channel values
    logic                        d_vld_reg;
    logic signed [PW-1:0]        v_reg [3];
    logic [pls_pkg::LIGHT_W-1:0] ld_reg;
    logic                        gd_reg;

    // output
    logic                        out_vld_reg;
    logic [7:0]                  byte_reg [3];

    assign en  = !out_vld_reg || pix.ready;
    assign pop = en && fifo_vld;

    assign a_lf   = PCT_TAB[lightness];
    assign a_sf   = PCT_TAB[fifo_data.sat];
    assign a_grey = (fifo_data.sat == '0);
    assign hprod  = HPW'(fifo_data.hue) * HPW'(HUE_RECIP);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hf_reg  <= hprod[HPW-1:HS];
            la_reg  <= lightness;
            ga_reg  <= a_grey;
            lfa_reg <= a_lf;
            sfa_reg <= a_sf;
        end
    end

    always_comb
    begin
        mb    = (la_reg < pls_pkg::LIGHT_HALF) ? ((QW+1)'(ONE) + (QW+1)'(sfa_reg))
                                               : (QW+1)'(sfa_reg);
        mprod = MW'(lfa_reg) * MW'(mb);
        if (la_reg < pls_pkg::LIGHT_HALF)
            t1_u = mprod[MW-1:FRAC_BITS];
        else
            t1_u = (QW+2)'(lfa_reg) + (QW+2)'(sfa_reg) - mprod[MW-1:FRAC_BITS];
        trs = (QW+1)'(hf_reg) + (QW+1)'(K3);
        tr  = (trs > (QW+1)'(ONE)) ? QW'(trs - (QW+1)'(ONE)) : QW'(trs);
        tb  = (hf_reg >= K3) ? (hf_reg - K3) : (hf_reg + ONE - K3);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg    <= $signed(PW'(t1_u));
            t2_reg    <= $signed(PW'({lfa_reg, 1'b0})) - $signed(PW'(t1_u));
            ph_reg[0] <= tr;
            ph_reg[1] <= hf_reg;
            ph_reg[2] <= tb;
            lb_reg    <= la_reg;
            gb_reg    <= ga_reg;
            t1c_reg   <= t1_reg;
            t2c_reg   <= t2_reg;
            lc_reg    <= lb_reg;
            gc_reg    <= gb_reg;
            ld_reg    <= lc_reg;
            gd_reg    <= gc_reg;
        end
    end

    assign d12 = t1_reg - t2_reg;

    for (genvar k = 0; k < 3; k++) begin : g_lane
        logic [PW-1:0]          t6;
        logic signed [PW-1:0]   diff, m;
        pls_pkg::seg_t          seg;
        logic signed [2*PW-1:0] mag;
        logic [2*PW-1:0]        qm;
        logic signed [PW-1:0]   qv, v;
        logic [CW-1:0]          p100;
        logic [CW-FRAC_BITS-1:0] cwide;
        logic [6:0]             c;

        always_comb
        begin
            t6   = PW'(ph_reg[k]) * PW'(6);
            diff = $signed(PW'(K6)) - $signed(PW'(ph_reg[k]));
            if (t6 < PW'(ONE))
                seg = pls_pkg::SEG_RISE;
            else if ((PW'(ph_reg[k]) << 1) < PW'(ONE))
                seg = pls_pkg::SEG_TOP;
            else if (PW'(ph_reg[k]) * PW'(3) < (PW'(ONE) << 1))
                seg = pls_pkg::SEG_FALL;
            else
                seg = pls_pkg::SEG_BOT;
            m = (seg == pls_pkg::SEG_RISE) ? $signed(t6) : ((diff <<< 1) + (diff <<< 2));
        end

        always_comb
        begin
            mag = (prod_reg[k] < 0) ? -prod_reg[k] : prod_reg[k];
            qm  = $unsigned(mag) >> FRAC_BITS;
            qv  = $signed(qm[PW-1:0]);
            if (prod_reg[k] < 0) qv = -qv;
            case (seg_reg[k])
                pls_pkg::SEG_RISE: v = t2c_reg + qv;
                pls_pkg::SEG_TOP:  v = t1c_reg;
                pls_pkg::SEG_FALL: v = t2c_reg + qv;
                pls_pkg::SEG_BOT:  v = t2c_reg;
                default:           v = t2c_reg;
            endcase
        end

        always_comb
        begin
            p100  = CW'(v_reg[k][PW-2:0]) * CW'(100);
            cwide = p100[CW-1:FRAC_BITS];
            if (v_reg[k] < 0)
                c = '0;
            else if (cwide > (CW-FRAC_BITS)'(100))
                c = 7'd100;
            else
                c = cwide[6:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                prod_reg[k] <= (2*PW)'(d12) * (2*PW)'(m);
                seg_reg[k]  <= seg;
                v_reg[k]    <= v;
                byte_reg[k] <= gd_reg ? BYTE_TAB[ld_reg] : BYTE_TAB[c];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            c_vld_reg   <= 1'b0;
            d_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg   <= fifo_vld;
            b_vld_reg   <= a_vld_reg;
            c_vld_reg   <= b_vld_reg;
            d_vld_reg   <= c_vld_reg;
            out_vld_reg <= d_vld_reg;
        end
    end

    assign pix.valid     = out_vld_reg;
    assign pix.red_out   = byte_reg[0];
    assign pix.green_out = byte_reg[1];
    assign pix.blue_out  = byte_reg[2];

endmodule

// File: hw/rtl/pixel_lightness_shade_top.sv
// Re-shades an 8-bit RGB pixel to the lightness in target register (percent, reset 50,
// writes above 100 saturate). One pixel is taken per clock unless the queue is full. An input
// pixel passes through FRAC_BITS+1 stages of the two bit-serial pipelined saturation/hue
// dividers in the front, one quotient bit per stage, one queue slot, and five back-end
// stages (hue fraction by reciprocal multiply, t1/t2, products, channel values, output
// bytes). A two-entry queue separates front and back so either side may stall alone.
// Write the lightness only while no pixel is in flight.
module pixel_lightness_shade_top #(
    parameter int FRAC_BITS = pls_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    pls_in_if.sink                      pix_in,
    pls_out_if.source                   pix_out,
    input  logic                        cfg_we,
    input  logic [pls_pkg::LIGHT_W-1:0] cfg_wdata
);

    logic [pls_pkg::LIGHT_W-1:0] light_reg, light_next;
    logic                        push, pop, full, fifo_vld;
    pls_pkg::hs_t                push_data, pop_data;

    assign light_next = (cfg_wdata > pls_pkg::LIGHT_MAX) ? pls_pkg::LIGHT_MAX : cfg_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_reg <= pls_pkg::LIGHT_RESET;
        end
        else if (cfg_we)
        begin
            light_reg <= light_next;
        end
    end

    pls_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix_in),
        .full      (full),
        .push      (push),
        .push_data (push_data)
    );

    pls_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (full),
        .vld       (fifo_vld),
        .pop_data  (pop_data)
    );

    pls_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .lightness (light_reg),
        .fifo_vld  (fifo_vld),
        .fifo_data (pop_data),
        .pop       (pop),
        .pix       (pix_out)
    );

endmodule
